// ===== rtl/skle_pkg.sv =====
// Shared types, sizes and codes for the sorted keyed list engine.
// No dependencies.
package skle_pkg;

    localparam int CAPACITY = 32;
    localparam int MAX_OUT  = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEFT_W   = $clog2(MAX_OUT + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [31:0] key_word2;
        logic [30:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [63:0] out_key0;
        logic [63:0] out_key1;
        logic [31:0] out_key2;
        logic [30:0] out_value;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [31:0] key2;
        logic [30:0] value;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/skle_ram.sv =====
// Entry memory: one write port, one read port, registered read data.
// Depends on skle_pkg.
module skle_ram
    import skle_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rd_data
);

    entry_t mem_reg [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem_reg[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_keyed_list_engine.sv =====
// Top level of the sorted keyed list engine: control sequencer around the entry memory.
// Depends on skle_pkg and skle_ram.
//
// channel | direction | handshake           | payload
// cmd     | in        | cmd_valid/cmd_stall | in_item_t
// res     | out       | res_valid/res_stall | out_item_t
//
// Insert/remove over N stored entries: accept, a scan of the stored entries, decide,
// S_SH_RD and S_SH_WR per moved entry, S_PUT to place a new entry, then a reply step.
// Dump: accept, then S_DUMP_RD and S_DUMP_OUT per emitted entry; empty dump: a reply.
// Any reply or dump entry waits while res_stall holds the output register.
// Reset empties the list at once; no clearing pass. cmd_stall is high whenever busy.
module sorted_keyed_list_engine
    import skle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  in_item_t  cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_DECIDE   = 4'd2;
    localparam logic [3:0] S_SH_RD    = 4'd3;
    localparam logic [3:0] S_SH_WR    = 4'd4;
    localparam logic [3:0] S_PUT      = 4'd5;
    localparam logic [3:0] S_DUMP_RD  = 4'd6;
    localparam logic [3:0] S_DUMP_OUT = 4'd7;
    localparam logic [3:0] S_REPLY    = 4'd8;

    logic [3:0]        state_reg, state_next;
    in_item_t          in_reg, in_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0] chk_idx_reg, chk_idx_next;
    logic              dup_reg, dup_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              pos_set_reg, pos_set_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [1:0]        status_reg, status_next;
    out_item_t         out_reg, out_next;
    logic              out_vld_reg, out_vld_next;

    ram_req_t          req;
    entry_t            rd_data;
    entry_t            new_entry;
    logic              out_free;
    logic              is_insert;

    skle_ram u_ram (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign out_free  = !out_vld_reg || !res_stall;
    assign is_insert = (in_reg.command == CMD_INSERT);
    assign new_entry = '{key0: in_reg.key_word0, key1: in_reg.key_word1,
                         key2: in_reg.key_word2, value: in_reg.value};

    always_comb
    begin
        state_next   = state_reg;
        in_next      = in_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        dup_next     = dup_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        pos_set_next = pos_set_reg;
        left_next    = left_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && res_stall;
        req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    in_next      = cmd;
                    idx_next     = '0;
                    dup_next     = 1'b0;
                    found_next   = '0;
                    pos_next     = cnt_reg;
                    pos_set_next = 1'b0;
                    status_next  = ST_DONE;
                    if (cmd.command == CMD_INSERT || cmd.command == CMD_REMOVE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (cmd.command == CMD_DUMP && cnt_reg != '0)
                    begin
                        idx_next = cnt_reg - CNT_W'(1);
                        if (32'(cnt_reg) > MAX_OUT)
                        begin
                            left_next = LEFT_W'(MAX_OUT);
                        end
                        else
                        begin
                            left_next = LEFT_W'(cnt_reg);
                        end
                        state_next = S_DUMP_RD;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    req.re       = 1'b1;
                    req.raddr    = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[ADDR_W-1:0];
                end
                else if (!chk_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
                if (chk_vld_reg)
                begin
                    if (rd_data.key0 == in_reg.key_word0 && rd_data.key1 == in_reg.key_word1
                        && rd_data.key2 == in_reg.key_word2)
                    begin
                        dup_next   = 1'b1;
                        found_next = CNT_W'(chk_idx_reg);
                    end
                    if (!pos_set_reg && rd_data.value <= in_reg.value)
                    begin
                        pos_next     = CNT_W'(chk_idx_reg);
                        pos_set_next = 1'b1;
                    end
                end
            end
            S_DECIDE:
            begin
                if (is_insert)
                begin
                    if (dup_reg)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_REPLY;
                    end
                    else if (cnt_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_REPLY;
                    end
                    else
                    begin
                        idx_next   = cnt_reg;
                        state_next = (cnt_reg > pos_reg) ? S_SH_RD : S_PUT;
                    end
                end
                else
                begin
                    if (!dup_reg)
                    begin
                        status_next = ST_NOTFOUND;
                        state_next  = S_REPLY;
                    end
                    else if ((found_reg + CNT_W'(1)) < cnt_reg)
                    begin
                        idx_next   = found_reg;
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_REPLY;
                    end
                end
            end
            S_SH_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = is_insert ? (idx_reg[ADDR_W-1:0] - ADDR_W'(1))
                                       : (idx_reg[ADDR_W-1:0] + ADDR_W'(1));
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg[ADDR_W-1:0];
                req.wdata = rd_data;
                if (is_insert)
                begin
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = ((idx_reg - CNT_W'(1)) > pos_reg) ? S_SH_RD : S_PUT;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if ((idx_reg + CNT_W'(2)) < cnt_reg)
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_REPLY;
                    end
                end
            end
            S_PUT:
            begin
                req.we     = 1'b1;
                req.waddr  = pos_reg[ADDR_W-1:0];
                req.wdata  = new_entry;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_REPLY;
            end
            S_DUMP_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = idx_reg[ADDR_W-1:0];
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_next = '{status: ST_DONE, entry_valid: 1'b1,
                                 out_key0: rd_data.key0, out_key1: rd_data.key1,
                                 out_key2: rd_data.key2, out_value: rd_data.value,
                                 last: (left_reg == LEFT_W'(1))};
                    out_vld_next = 1'b1;
                    left_next    = left_reg - LEFT_W'(1);
                    idx_next     = idx_reg - CNT_W'(1);
                    state_next   = (left_reg == LEFT_W'(1)) ? S_IDLE : S_DUMP_RD;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_next        = '0;
                    out_next.status = status_reg;
                    out_next.last   = 1'b1;
                    out_vld_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        dup_reg     <= dup_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        pos_set_reg <= pos_set_next;
        left_reg    <= left_next;
        status_reg  <= status_next;
        out_reg     <= out_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_vld_reg;
    assign res       = out_reg;

endmodule
